/* rtl/core/sva_pkg.sv */
// Package: shared request, action, status and mode codes, plus delay and result limits, of the sleep vote arbiter.
`timescale 1ns / 1ps
`default_nettype none
package sva_pkg;
  localparam logic [2:0] REQ_REGISTER   = 3'd0;
  localparam logic [2:0] REQ_UNREGISTER = 3'd1;
  localparam logic [2:0] REQ_VOTE       = 3'd2;
  localparam logic [2:0] REQ_ONLINE     = 3'd3;
  localparam logic [2:0] REQ_WOKE       = 3'd4;
  localparam logic [2:0] REQ_ASLEEP     = 3'd5;
  localparam logic [2:0] REQ_STATUS     = 3'd6;
  localparam logic [2:0] REQ_TIMER      = 3'd7;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_SLEEP    = 3'd1;
  localparam logic [2:0] ACT_WAKE     = 3'd2;
  localparam logic [2:0] ACT_NOTE_ON  = 3'd3;
  localparam logic [2:0] ACT_NOTE_OFF = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_WRONG_ID = 2'd2;
  localparam logic [1:0] ST_ROLE     = 2'd3;

  localparam logic [31:0] INFINITE_DELAY = 32'hFFFF_FFFF;
  localparam int unsigned MAX_RESULTS = 9;

  typedef enum logic [1:0] {
    MODE_ONLINE   = 2'd0,
    MODE_ENTERING = 2'd1,
    MODE_OFFLINE  = 2'd2
  } power_mode_t;
endpackage
`default_nettype wire

/* rtl/core/sleep_vote_arbiter_top.sv */
// Top level: slot table, slot-scan sequencer and result emitter of the sleep vote arbiter.
// Flow: status, wake timer, request online, a non-confirm asleep and a rejected vote or
//   unregister end in S_DECIDE; register scans, then emits; stack woke scans, then tails;
//   accepted vote or unregister decides, scans, emits; asleep confirm decides, scans,
//   tails. All results are out by the cycle after busy falls; one transaction at a time.
// Results appear for one cycle each under result_valid; the receiver cannot stall.
// Reset (rst, synchronous): slots free, mode online, role_allows_sleep set to 1.
`timescale 1ns / 1ps
`default_nettype none
module sleep_vote_arbiter_top
  import sva_pkg::*;
#(
  parameter int MODULE_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [2:0]  module_id,
  input  wire logic [31:0] delay_s,
  input  wire logic [31:0] now_s,
  input  wire logic        stack_asleep,
  input  wire logic        wants_online_note,
  input  wire logic        wants_offline_note,
  output logic             result_valid,
  output logic [1:0]       status,
  output logic [2:0]       assigned_id,
  output logic [2:0]       action,
  output logic [2:0]       target_module,
  output logic [31:0]      delay_out,
  output logic [31:0]      elapsed_s,
  output logic             is_offline,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int SW = (MODULE_SLOTS > 1) ? $clog2(MODULE_SLOTS) : 1;
  localparam int CW = $clog2(MODULE_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_EMIT, S_TAIL
  } state_t;

  state_t state;

  // Slot table; deadlines and wishes have no reset.
  logic [MODULE_SLOTS-1:0] slot_in_use, slot_ready;
  logic [MODULE_SLOTS-1:0] slot_note_online, slot_note_offline;
  logic [31:0]             slot_deadline [MODULE_SLOTS];

  power_mode_t power_mode;
  logic        wake_pending;
  logic [31:0] sleep_start_time, next_wake_time;
  logic        role_allows_sleep;

  // Captured transaction.
  logic [2:0]  q_req, q_id;
  logic [31:0] q_dly, q_now;
  logic        q_asleep, q_won, q_woff;

  // Scan state.
  logic [CW-1:0] idx;
  logic [31:0]   min_dl;
  logic          all_ready;
  logic          free_found;
  logic [SW-1:0] free_slot;
  logic [3:0]    n_out;
  logic          tail_wake;
  logic [31:0]   off_delay;

  // Shared subtract/compare unit.
  logic [31:0] sub_a, sub_b, sub_diff;
  logic        sub_lt;
  assign sub_diff = sub_a - sub_b;
  assign sub_lt   = sub_a < sub_b;

  logic [SW-1:0] cur;
  assign cur = idx[SW-1:0];

  logic id_ok;
  assign id_ok = ({29'd0, q_id} < 32'(MODULE_SLOTS)) && slot_in_use[q_id[SW-1:0]];

  logic [31:0] cur_dl;
  assign cur_dl = slot_deadline[cur];

  // Slots above the scan position; a notification is the last one when none of them notify.
  logic [MODULE_SLOTS-1:0] later_mask;
  always_comb begin
    for (int i = 0; i < MODULE_SLOTS; i++) later_mask[i] = (SW'(i) > cur);
  end

  logic more_on, more_off;
  assign more_on  = |(slot_in_use & slot_note_online & later_mask);
  assign more_off = |(slot_in_use & slot_note_offline & later_mask);

  always_comb begin
    sub_a = min_dl;
    sub_b = q_now;
    unique case (state)
      S_SCAN: begin
        sub_a = cur_dl;
        sub_b = q_now;
      end
      S_DECIDE: begin
        if (q_req == REQ_ASLEEP) begin
          sub_a = next_wake_time;
          sub_b = q_now;
        end else if (q_req == REQ_STATUS) begin
          sub_a = q_now;
          sub_b = sleep_start_time;
        end else begin
          sub_a = min_dl;
          sub_b = q_now;
        end
      end
      default: begin
        sub_a = min_dl;
        sub_b = q_now;
      end
    endcase
  end

  assign pready = 1'b1;
  assign prdata = {31'd0, role_allows_sleep};
  assign busy   = (state != S_IDLE);

  task automatic put(input logic [1:0] st, input logic [2:0] id, input logic [2:0] act,
                     input logic [2:0] tgt, input logic [31:0] d, input logic [31:0] el,
                     input logic off, input logic lst);
    result_valid  <= 1'b1;
    status        <= st;
    assigned_id   <= id;
    action        <= act;
    target_module <= tgt;
    delay_out     <= d;
    elapsed_s     <= el;
    is_offline    <= off;
    last          <= lst;
  endtask

  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state             <= S_IDLE;
      slot_in_use       <= '0;
      slot_ready        <= '0;
      power_mode        <= MODE_ONLINE;
      wake_pending      <= 1'b0;
      sleep_start_time  <= '0;
      next_wake_time    <= '0;
      role_allows_sleep <= 1'b1;
      last              <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 3'd0) begin
        role_allows_sleep <= pwdata[0];
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            q_req <= req_type; q_id <= module_id; q_dly <= delay_s; q_now <= now_s;
            q_asleep <= stack_asleep; q_won <= wants_online_note;
            q_woff <= wants_offline_note;
            // Register and stack woke scan first; everything else decides first.
            state <= (req_type == REQ_REGISTER || req_type == REQ_WOKE) ? S_SCAN : S_DECIDE;
            idx <= '0; min_dl <= INFINITE_DELAY; all_ready <= 1'b1;
            free_found <= 1'b0; free_slot <= '0; n_out <= '0; tail_wake <= 1'b0;
          end
        end
        S_SCAN: begin
          if (q_req == REQ_REGISTER) begin
            if (!slot_in_use[cur] && !free_found) begin
              free_found <= 1'b1; free_slot <= cur;
            end
          end else if (q_req == REQ_WOKE) begin
            if (slot_in_use[cur]) begin
              slot_ready[cur] <= 1'b0;
              if (slot_note_online[cur]) begin
                put(ST_OK, 3'd0, ACT_NOTE_ON, 3'(cur),
                    (cur_dl == INFINITE_DELAY) ? INFINITE_DELAY :
                    (sub_lt ? 32'd0 : sub_diff), 32'd0, 1'b0, !more_on);
                n_out <= n_out + 4'd1;
              end
            end
          end else if (q_req == REQ_ASLEEP) begin
            if (slot_in_use[cur] && slot_note_offline[cur] &&
                n_out < 4'(MAX_RESULTS)) begin
              put(ST_OK, 3'd0, ACT_NOTE_OFF, 3'(cur), off_delay, 32'd0, 1'b0,
                  !more_off && !tail_wake);
              n_out <= n_out + 4'd1;
            end
          end else begin
            if (slot_in_use[cur]) begin
              if (!slot_ready[cur]) all_ready <= 1'b0;
              if (cur_dl < min_dl) min_dl <= cur_dl;
            end
          end
          idx <= idx + CW'(1);
          if (idx == CW'(MODULE_SLOTS - 1)) begin
            state <= (q_req == REQ_WOKE || q_req == REQ_ASLEEP) ? S_TAIL : S_EMIT;
          end
        end
        S_DECIDE: begin
          state <= S_IDLE;
          priority case (q_req)
            REQ_UNREGISTER, REQ_VOTE: begin
              if (!id_ok) begin
                put(ST_WRONG_ID, 3'd0, ACT_NONE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
              end else begin
                if (q_req == REQ_UNREGISTER) slot_in_use[q_id[SW-1:0]] <= 1'b0;
                else begin
                  slot_deadline[q_id[SW-1:0]] <=
                    (q_dly == INFINITE_DELAY) ? INFINITE_DELAY : q_now + q_dly;
                  slot_ready[q_id[SW-1:0]] <= 1'b1;
                end
                idx <= '0; min_dl <= INFINITE_DELAY; all_ready <= 1'b1;
                q_req <= REQ_TIMER; // marks rescan as sleep evaluation
                q_id  <= q_req;     // remember original request
                state <= S_SCAN;
              end
            end
            REQ_ONLINE: begin
              if (!id_ok) begin
                put(ST_WRONG_ID, 3'd0, ACT_NONE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
              end else begin
                next_wake_time <= '0;
                if (power_mode == MODE_ENTERING) wake_pending <= 1'b1;
                put(ST_OK, 3'd0, (power_mode == MODE_ENTERING) ? ACT_NONE : ACT_WAKE,
                    3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
              end
            end
            REQ_ASLEEP: begin
              if (q_asleep && power_mode == MODE_ENTERING) begin
                power_mode <= MODE_OFFLINE;
                off_delay  <= sub_lt ? 32'd0 : sub_diff;
                tail_wake  <= wake_pending;
                idx <= '0;
                state <= S_SCAN;
              end else begin
                put(ST_OK, 3'd0, ACT_NONE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
              end
            end
            REQ_STATUS: begin
              put(ST_OK, 3'd0, ACT_NONE, 3'd0, q_asleep ? next_wake_time - q_now : 32'd0,
                  q_asleep ? sub_diff : 32'd0, q_asleep, 1'b1);
            end
            default: begin
              if (power_mode == MODE_ENTERING) wake_pending <= 1'b1;
              put(ST_OK, 3'd0, (power_mode == MODE_ENTERING) ? ACT_NONE : ACT_WAKE,
                  3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
            end
          endcase
        end
        S_EMIT: begin
          state <= S_IDLE;
          if (q_req == REQ_REGISTER) begin
            if (!role_allows_sleep) begin
              put(ST_ROLE, 3'd0, ACT_NONE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
            end else if (!free_found) begin
              put(ST_NO_SLOT, 3'd0, ACT_NONE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
            end else begin
              slot_in_use[free_slot]       <= 1'b1;
              slot_ready[free_slot]        <= 1'b0;
              slot_note_online[free_slot]  <= q_won;
              slot_note_offline[free_slot] <= q_woff;
              if (q_asleep) begin
                next_wake_time <= '0;
                if (power_mode == MODE_ENTERING) wake_pending <= 1'b1;
              end
              put(ST_OK, 3'(free_slot),
                  (q_asleep && power_mode != MODE_ENTERING) ? ACT_WAKE : ACT_NONE,
                  3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
            end
          end else begin
            // Sleep evaluation after vote or unregister.
            if (all_ready) begin
              next_wake_time <= sub_lt ? q_now : min_dl;
              if (!q_asleep) begin
                sleep_start_time <= q_now;
                power_mode <= MODE_ENTERING;
              end
              put(ST_OK, 3'd0, ACT_SLEEP, 3'd0, sub_lt ? 32'd0 : sub_diff,
                  32'd0, 1'b0, 1'b1);
            end else begin
              put(ST_OK, 3'd0, ACT_NONE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
            end
          end
        end
        S_TAIL: begin
          state <= S_IDLE;
          if (q_req == REQ_WOKE) power_mode <= MODE_ONLINE;
          // Release a held wake, or answer with no action when nothing was sent.
          if (q_req == REQ_ASLEEP && tail_wake) begin
            wake_pending <= 1'b0;
            put(ST_OK, 3'd0, ACT_WAKE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
          end else if (n_out == 4'd0) begin
            put(ST_OK, 3'd0, ACT_NONE, 3'd0, 32'd0, 32'd0, 1'b0, 1'b1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Reset drops the result strobe.
  assert property (@(posedge clk) rst |=> !result_valid);
  // An accepted transaction holds busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy);
  // Only the final result of a transaction may show after busy falls.
  assert property (@(posedge clk) disable iff (rst) (result_valid && !last) |-> busy);
  // Only defined action codes leave the block.
  assert property (@(posedge clk) disable iff (rst)
                   result_valid |-> (action <= ACT_NOTE_OFF));
  assert property (@(posedge clk) pready);
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for sleep_vote_arbiter_top: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_top
  import sva_pkg::*;
;

  localparam int SLOTS      = 8;
  localparam int CYC_LIMIT  = 200000;
  localparam int RAND_ITEMS = 300;

  typedef struct packed {
    logic [2:0]  req;
    logic [2:0]  id;
    logic [31:0] dly;
    logic [31:0] now;
    logic        asleep;
    logic        won;
    logic        woff;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  assigned_id;
    logic [2:0]  action;
    logic [2:0]  target_module;
    logic [31:0] delay_out;
    logic [31:0] elapsed_s;
    logic        is_offline;
    logic        last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  req_type = '0;
  logic [2:0]  module_id = '0;
  logic [31:0] delay_s = '0;
  logic [31:0] now_s = '0;
  logic        stack_asleep = 1'b0;
  logic        wants_online_note = 1'b0;
  logic        wants_offline_note = 1'b0;
  logic        result_valid;
  logic [1:0]  status;
  logic [2:0]  assigned_id;
  logic [2:0]  action;
  logic [2:0]  target_module;
  logic [31:0] delay_out;
  logic [31:0] elapsed_s;
  logic        is_offline;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sleep_vote_arbiter_top #(.MODULE_SLOTS(SLOTS)) dut (.*);

  always #6 clk = ~clk;

  // Shadow copy of the arbiter state
  logic        role_ok;
  logic        in_use [SLOTS];
  logic        ready [SLOTS];
  logic        voted [SLOTS];   // deadline written since the slot was granted
  logic [31:0] deadline [SLOTS];
  logic        note_on [SLOTS];
  logic        note_off [SLOTS];
  power_mode_t mode;
  logic        wake_held;
  logic [31:0] sleep_start;
  logic [31:0] wake_time;

  outcome_t    pending_q[$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned sleeps_seen = 0;
  bit          no_idle = 1'b0;
  logic [31:0] clock_s = 32'd1000;

  // Bounded run: a hang anywhere ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result checker: every strobed result is matched against the oldest prediction
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && result_valid) begin
      got = '{status, assigned_id, action, target_module, delay_out, elapsed_s,
              is_offline, last};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got.action == ACT_SLEEP) sleeps_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic clear_shadow();
    role_ok = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      in_use[i] = 1'b0; ready[i] = 1'b0; voted[i] = 1'b0;
      deadline[i] = '0; note_on[i] = 1'b0; note_off[i] = 1'b0;
    end
    mode = MODE_ONLINE;
    wake_held = 1'b0;
    sleep_start = '0;
    wake_time = '0;
  endtask

  function automatic outcome_t mk(logic [1:0] st, logic [2:0] aid, logic [2:0] act,
                                  logic [2:0] tgt, logic [31:0] d, logic [31:0] el,
                                  logic off);
    mk = '{st, aid, act, tgt, d, el, off, 1'b0};
  endfunction

  // Wake request: held back while entering offline, else issued
  function automatic logic [2:0] wake_action();
    if (mode == MODE_ENTERING) begin
      wake_held = 1'b1;
      return ACT_NONE;
    end
    return ACT_WAKE;
  endfunction

  // All in-use modules ready: return 1 and the clamped delay to the earliest deadline
  function automatic logic try_sleep(logic [31:0] now, logic asleep, output logic [31:0] d);
    logic [31:0] dl;
    dl = INFINITE_DELAY;
    d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (in_use[i]) begin
        if (!ready[i]) return 1'b0;
        if (deadline[i] < dl) dl = deadline[i];
      end
    end
    d = (now > dl) ? 32'd0 : dl - now;
    wake_time = now + d;
    if (!asleep) begin
      sleep_start = now;
      mode = MODE_ENTERING;
    end
    return 1'b1;
  endfunction

  // Work out the results of one accepted transaction and queue them
  task automatic predict_outcomes(request_t r);
    outcome_t    batch[$];
    logic [31:0] d;
    logic [2:0]  act;
    int          slot;
    logic        ok;
    d = '0;
    slot = -1;
    case (r.req)
      REQ_REGISTER: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!in_use[i]) slot = i;
        if (!role_ok) batch.push_back(mk(ST_ROLE, 0, ACT_NONE, 0, 0, 0, 0));
        else if (slot < 0) batch.push_back(mk(ST_NO_SLOT, 0, ACT_NONE, 0, 0, 0, 0));
        else begin
          in_use[slot] = 1'b1; ready[slot] = 1'b0; voted[slot] = 1'b0;
          note_on[slot] = r.won; note_off[slot] = r.woff;
          act = ACT_NONE;
          if (r.asleep) begin
            wake_time = '0;
            act = wake_action();
          end
          batch.push_back(mk(ST_OK, slot[2:0], act, 0, 0, 0, 0));
        end
      end
      REQ_UNREGISTER, REQ_VOTE: begin
        if (!in_use[r.id]) batch.push_back(mk(ST_WRONG_ID, 0, ACT_NONE, 0, 0, 0, 0));
        else begin
          if (r.req == REQ_UNREGISTER) in_use[r.id] = 1'b0;
          else begin
            deadline[r.id] = (r.dly == INFINITE_DELAY) ? INFINITE_DELAY : r.now + r.dly;
            ready[r.id] = 1'b1;
            voted[r.id] = 1'b1;
          end
          ok = try_sleep(r.now, r.asleep, d);
          batch.push_back(mk(ST_OK, 0, ok ? ACT_SLEEP : ACT_NONE, 0, ok ? d : 32'd0, 0, 0));
        end
      end
      REQ_ONLINE: begin
        if (!in_use[r.id]) batch.push_back(mk(ST_WRONG_ID, 0, ACT_NONE, 0, 0, 0, 0));
        else begin
          wake_time = '0;
          batch.push_back(mk(ST_OK, 0, wake_action(), 0, 0, 0, 0));
        end
      end
      REQ_WOKE: begin
        mode = MODE_ONLINE;
        for (int i = 0; i < SLOTS; i++) begin
          if (in_use[i]) begin
            ready[i] = 1'b0;
            if (note_on[i]) begin
              if (deadline[i] == INFINITE_DELAY) d = INFINITE_DELAY;
              else d = (deadline[i] < r.now) ? 32'd0 : deadline[i] - r.now;
              batch.push_back(mk(ST_OK, 0, ACT_NOTE_ON, i[2:0], d, 0, 0));
            end
          end
        end
      end
      REQ_ASLEEP: begin
        if (r.asleep && mode == MODE_ENTERING) begin
          mode = MODE_OFFLINE;
          d = (wake_time < r.now) ? 32'd0 : wake_time - r.now;
          for (int i = 0; i < SLOTS; i++)
            if (in_use[i] && note_off[i])
              batch.push_back(mk(ST_OK, 0, ACT_NOTE_OFF, i[2:0], d, 0, 0));
          if (wake_held) begin
            batch.push_back(mk(ST_OK, 0, wake_action(), 0, 0, 0, 0));
            wake_held = 1'b0;
          end
        end
      end
      REQ_STATUS: begin
        if (r.asleep)
          batch.push_back(mk(ST_OK, 0, ACT_NONE, 0, wake_time - r.now,
                             r.now - sleep_start, 1'b1));
        else batch.push_back(mk(ST_OK, 0, ACT_NONE, 0, 0, 0, 0));
      end
      default: batch.push_back(mk(ST_OK, 0, wake_action(), 0, 0, 0, 0));
    endcase
    if (batch.size() == 0) batch.push_back(mk(ST_OK, 0, ACT_NONE, 0, 0, 0, 0));
    while (batch.size() > MAX_RESULTS) void'(batch.pop_back());
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pending_q.push_back(batch[k]);
  endtask

  // Send one transaction; called and returns at a falling edge
  task automatic send_request(request_t r);
    if (!no_idle && $urandom_range(0, 99) < 29) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_type = r.req; module_id = r.id; delay_s = r.dly; now_s = r.now;
    stack_asleep = r.asleep; wants_online_note = r.won; wants_offline_note = r.woff;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_outcomes(r);
    sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic request_t req_of(logic [2:0] rq, logic [2:0] id, logic [31:0] dly,
                                      logic [31:0] now, logic asl, logic won, logic woff);
    req_of = '{rq, id, dly, now, asl, won, woff};
  endfunction

  // Write role_allows_sleep once the block has drained
  task automatic write_role(logic v);
    while (pending_q.size() != 0 || busy) @(negedge clk);
    repeat (14) @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = 3'd0; pwdata = {31'd0, v}; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    pwdata = $urandom();
    role_ok = v;
  endtask

  // Fill the table, overflow it, hit bad ids and the wrong-role answer
  task automatic test_registration();
    send_request(req_of(REQ_STATUS, 0, 0, 32'd50, 1'b0, 0, 0));
    for (int i = 0; i < SLOTS; i++)
      send_request(req_of(REQ_REGISTER, 0, 0, clock_s, 1'b0, i[0], i[1]));
    send_request(req_of(REQ_REGISTER, 0, 0, clock_s, 1'b0, 1, 1));
    send_request(req_of(REQ_UNREGISTER, 3'd7, 0, clock_s, 1'b0, 0, 0));
    send_request(req_of(REQ_VOTE, 3'd7, 32'd5, clock_s, 1'b0, 0, 0));
    send_request(req_of(REQ_ONLINE, 3'd7, 0, clock_s, 1'b0, 0, 0));
    write_role(1'b0);
    send_request(req_of(REQ_REGISTER, 0, 0, clock_s, 1'b0, 1, 1));
    write_role(1'b1);
  endtask

  // Vote everyone ready, hold a wake while entering offline, confirm, query, wake up
  task automatic test_sleep_cycle();
    send_request(req_of(REQ_VOTE, 3'd0, INFINITE_DELAY, clock_s, 1'b0, 0, 0));
    send_request(req_of(REQ_VOTE, 3'd1, 32'hFFFF_FFFE, clock_s, 1'b0, 0, 0));
    for (int i = 2; i < SLOTS - 1; i++)
      send_request(req_of(REQ_VOTE, i[2:0], 32'd100 + i, clock_s, 1'b0, 0, 0));
    send_request(req_of(REQ_TIMER, 0, 0, clock_s + 1, 1'b0, 0, 0));
    send_request(req_of(REQ_ASLEEP, 0, 0, clock_s + 2, 1'b0, 0, 0));
    send_request(req_of(REQ_ASLEEP, 0, 0, clock_s + 3, 1'b1, 0, 0));
    send_request(req_of(REQ_STATUS, 0, 0, clock_s + 9, 1'b1, 0, 0));
    send_request(req_of(REQ_REGISTER, 0, 0, clock_s + 10, 1'b1, 0, 1));
    send_request(req_of(REQ_WOKE, 0, 0, clock_s + 500, 1'b0, 0, 0));
    clock_s = clock_s + 600;
  endtask

  function automatic request_t random_request();
    request_t    r;
    int          pick;
    int          used[$];
    r = '0;
    for (int i = 0; i < SLOTS; i++) if (in_use[i]) used.push_back(i);
    pick = $urandom_range(0, 99);
    r.req = (pick < 14) ? REQ_REGISTER : (pick < 21) ? REQ_UNREGISTER :
            (pick < 50) ? REQ_VOTE : (pick < 57) ? REQ_ONLINE :
            (pick < 67) ? REQ_WOKE : (pick < 80) ? REQ_ASLEEP :
            (pick < 90) ? REQ_STATUS : REQ_TIMER;
    if (used.size() != 0 && $urandom_range(0, 99) < 80)
      r.id = used[$urandom_range(0, used.size() - 1)];
    else r.id = $urandom_range(0, SLOTS - 1);
    pick = $urandom_range(0, 9);
    r.dly = (pick == 0) ? INFINITE_DELAY : (pick < 7) ? $urandom_range(0, 300) : $urandom();
    if ($urandom_range(0, 19) == 0) clock_s = $urandom();
    else clock_s = clock_s + $urandom_range(0, 40);
    r.now = clock_s;
    r.asleep = (r.req == REQ_ASLEEP) ? ($urandom_range(0, 9) < 8)
                                     : (mode == MODE_OFFLINE) ^ ($urandom_range(0, 9) == 0);
    r.won = $urandom_range(0, 1);
    r.woff = $urandom_range(0, 1);
    // A wake-up must not read the deadline of a module that has not voted yet
    if (r.req == REQ_WOKE)
      for (int i = 0; i < SLOTS; i++)
        if (in_use[i] && note_on[i] && !voted[i]) begin
          r.req = REQ_VOTE;
          r.id = i;
        end
    return r;
  endfunction

  // Random traffic with role changes between phases and one stretch without idling
  task automatic test_random_traffic();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_idle = (n >= 120 && n < 180);
      if (n == 200) write_role(1'b0);
      if (n == 230) write_role(1'b1);
      send_request(random_request());
    end
  endtask

  initial begin
    clear_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_registration();
    test_sleep_cycle();
    test_random_traffic();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("Sent %0d requests, checked %0d results, %0d sleep requests seen.",
             sent, checked, sleeps_seen);
    $display("Covered slot table full/wrong id/role, held wakes, offline notes, status.");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
